/* sv/tgr_pkg.sv */
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, register indexes and helpers for the trilinear grid resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

    localparam logic [2:0] REG_X_SCALE    = 3'd0;
    localparam logic [2:0] REG_X_OFFSET   = 3'd1;
    localparam logic [2:0] REG_Y_SCALE    = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET   = 3'd3;
    localparam logic [2:0] REG_Z_SCALE    = 3'd4;
    localparam logic [2:0] REG_Z_OFFSET   = 3'd5;
    localparam logic [2:0] REG_SRC_YCOUNT = 3'd6;
    localparam logic [2:0] REG_SRC_ZCOUNT = 3'd7;

    localparam int QDEPTH = 2;
    localparam int IDX_W  = 22;     // integer part of a nonnegative coordinate, plus ceil

    typedef logic signed [31:0] t_sample;

    typedef struct packed {
        logic [23:0]        x_scale;
        logic signed [31:0] x_offset;
        logic [23:0]        y_scale;
        logic signed [31:0] y_offset;
        logic [23:0]        z_scale;
        logic signed [31:0] z_offset;
        logic [12:0]        src_ycount;
        logic [10:0]        src_zcount;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [15:0]      fr;
        logic             neg;
    } t_axis;

    typedef struct packed {
        logic        mode;
        logic [13:0] load_addr;
        t_sample     load_value;
        t_axis       ax;
        t_axis       ay;
        t_axis       az;
        logic        err;
    } t_item;

    // Split a Q16 source coordinate (scale * index + offset) into floor, ceil, fraction.
    function automatic t_axis axis_split(input logic [35:0] prod,
                                         input logic signed [31:0] offset);
        logic signed [37:0] c;
        t_axis a;
        c = $signed({2'b00, prod}) + 38'(offset);
        a.neg = c[37];
        if (c[37]) begin
            a.lo = '0;
            a.hi = '0;
            a.fr = '0;
        end else begin
            a.lo = c[37:16];
            a.fr = c[15:0];
            a.hi = c[37:16] + IDX_W'(|c[15:0]);
        end
        return a;
    endfunction

endpackage

`default_nettype wire

/* sv/tgr_fifo.sv */
// ----------------------------------------------------------------------------
// tgr_fifo
// Short item queue between the classifying front end and the blending back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tgr_pkg::t_item i_data,
    input  wire logic          i_pop,
    output tgr_pkg::t_item     o_data,
    output logic               o_full,
    output logic               o_empty
);
    localparam int PW = (tgr_pkg::QDEPTH > 1) ? $clog2(tgr_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(tgr_pkg::QDEPTH + 1);

    tgr_pkg::t_item r_mem [tgr_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(tgr_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(tgr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= next_ptr(r_wp);
            end
            if (i_pop) begin
                r_rp <= next_ptr(r_rp);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* sv/tgr_front.sv */
// ----------------------------------------------------------------------------
// tgr_front
// Accepts items, scales target indices to source coordinates and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_mode,
    input  wire logic [13:0]   i_load_addr,
    input  wire logic [31:0]   i_load_value,
    input  wire logic [11:0]   i_tgt_i,
    input  wire logic [11:0]   i_tgt_j,
    input  wire logic [9:0]    i_tgt_k,
    input  wire tgr_pkg::t_cfg i_cfg,
    input  wire logic          i_full,
    output logic               o_push,
    output tgr_pkg::t_item     o_item,
    output logic               o_busy
);
    logic          r_valid;
    logic          r_mode;
    logic [13:0]   r_addr;
    logic [31:0]   r_value;
    logic [35:0]   r_px, r_py, r_pz;
    tgr_pkg::t_axis w_ax, w_ay, w_az;

    assign o_busy = r_valid;
    assign o_push = r_valid && !i_full;

    always_comb begin
        w_ax = tgr_pkg::axis_split(r_px, i_cfg.x_offset);
        w_ay = tgr_pkg::axis_split(r_py, i_cfg.y_offset);
        w_az = tgr_pkg::axis_split(r_pz, i_cfg.z_offset);
        o_item.mode       = r_mode;
        o_item.load_addr  = r_addr;
        o_item.load_value = r_value;
        o_item.ax         = w_ax;
        o_item.ay         = w_ay;
        o_item.az         = w_az;
        o_item.err        = w_ax.neg | w_ay.neg | w_az.neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode  <= i_mode;
            r_addr  <= i_load_addr;
            r_value <= i_load_value;
            r_px    <= 36'(i_cfg.x_scale) * 36'(i_tgt_i);
            r_py    <= 36'(i_cfg.y_scale) * 36'(i_tgt_j);
            r_pz    <= 36'(i_cfg.z_scale) * 36'(i_tgt_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sv/tgr_back.sv */
// ----------------------------------------------------------------------------
// tgr_back
// Owns the source store: writes loads, fetches eight neighbours and blends them.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_back #(
    parameter int SRC_DEPTH = 16384
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tgr_pkg::t_item i_item,
    input  wire logic           i_empty,
    input  wire tgr_pkg::t_cfg  i_cfg,
    output logic                o_pop,
    output logic                o_valid,
    output logic [31:0]         o_value,
    output logic                o_error
);
    localparam int AW = $clog2(SRC_DEPTH);
    localparam logic [47:0] DEPTH_W = 48'(SRC_DEPTH);
    localparam logic [20:0] DEPTH_L = 21'(SRC_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_LERP = 2'd2;

    tgr_pkg::t_sample r_mem [SRC_DEPTH];

    logic [1:0]          r_state;
    tgr_pkg::t_item      r_cur;
    logic [3:0]          r_n;
    logic                r_v1, r_v2, r_v3;
    logic [2:0]          r_i1, r_i2, r_i3;
    logic                r_z1;
    logic [35:0]         r_m1;
    logic [47:0]         r_m2;
    logic                r_oob;
    tgr_pkg::t_sample    r_rd;
    tgr_pkg::t_sample    r_v [8];
    logic [2:0]          r_s;
    logic                r_ph;
    tgr_pkg::t_sample    r_a;
    logic signed [49:0]  r_prod;
    logic                r_out_valid;
    logic [31:0]         r_out_value;
    logic                r_out_error;

    logic                w_we;
    logic                w_issue;
    logic [tgr_pkg::IDX_W-1:0] w_xi, w_yi, w_zi;
    tgr_pkg::t_sample    w_la, w_lb;
    logic [15:0]         w_lf;
    logic signed [32:0]  w_diff;
    logic signed [50:0]  w_round;
    logic signed [35:0]  w_sum;
    tgr_pkg::t_sample    w_res;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign w_we    = o_pop && !i_item.mode && ({7'd0, i_item.load_addr} < DEPTH_L);
    assign w_issue = (r_state == ST_ADDR) && !r_n[3];

    assign w_xi = r_n[2] ? r_cur.ax.hi : r_cur.ax.lo;
    assign w_yi = r_n[1] ? r_cur.ay.hi : r_cur.ay.lo;
    assign w_zi = r_z1   ? r_cur.az.hi : r_cur.az.lo;

    // Pair schedule: four blends along z, two along y, one along x.
    always_comb begin
        unique case (r_s)
            3'd0: begin w_la = r_v[0]; w_lb = r_v[1]; w_lf = r_cur.az.fr; end
            3'd1: begin w_la = r_v[2]; w_lb = r_v[3]; w_lf = r_cur.az.fr; end
            3'd2: begin w_la = r_v[4]; w_lb = r_v[5]; w_lf = r_cur.az.fr; end
            3'd3: begin w_la = r_v[6]; w_lb = r_v[7]; w_lf = r_cur.az.fr; end
            3'd4: begin w_la = r_v[0]; w_lb = r_v[1]; w_lf = r_cur.ay.fr; end
            3'd5: begin w_la = r_v[2]; w_lb = r_v[3]; w_lf = r_cur.ay.fr; end
            default: begin w_la = r_v[4]; w_lb = r_v[5]; w_lf = r_cur.ax.fr; end
        endcase
    end

    assign w_diff  = 33'(w_lb) - 33'(w_la);
    assign w_round = 51'(r_prod) + 51'sd32768;
    assign w_sum   = 36'(r_a) + 36'(w_round >>> 16);
    assign w_res   = w_sum[31:0];

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(i_item.load_addr)] <= i_item.load_value;
        end else if (r_v2) begin
            r_rd <= r_mem[r_m2[AW-1:0]];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
        end
        r_m1 <= 36'(w_xi) * 36'(i_cfg.src_ycount) + 36'(w_yi);
        r_z1 <= r_n[0];
        r_i1 <= r_n[2:0];
        r_m2 <= 48'(r_m1) * 48'(i_cfg.src_zcount) + 48'(w_zi);
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        if (r_v3) begin
            r_v[r_i3] <= r_rd;
        end
        if (r_state == ST_LERP) begin
            if (!r_ph) begin
                r_prod <= w_diff * $signed({1'b0, w_lf});
                r_a    <= w_la;
            end else begin
                r_v[r_s] <= w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_oob       <= 1'b0;
            r_s         <= '0;
            r_ph        <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_value <= '0;
            r_out_error <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_v1        <= w_issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_item.mode) begin
                        if (i_item.err) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= '0;
                            r_out_error <= 1'b1;
                        end else begin
                            r_state <= ST_ADDR;
                            r_n     <= '0;
                            r_oob   <= 1'b0;
                        end
                    end
                end
                ST_ADDR: begin
                    if (w_issue) begin
                        r_n <= r_n + 1'b1;
                    end
                    if (r_v2 && (r_m2 >= DEPTH_W)) begin
                        r_oob <= 1'b1;
                    end
                    if (r_v3 && (r_i3 == 3'd7)) begin
                        if (r_oob) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= '0;
                            r_out_error <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_state <= ST_LERP;
                            r_s     <= '0;
                            r_ph    <= 1'b0;
                        end
                    end
                end
                ST_LERP: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_s == 3'd6) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= w_res;
                            r_out_error <= 1'b0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/trilinear_grid_resampler.sv */
// ----------------------------------------------------------------------------
// trilinear_grid_resampler
// Trilinear resampling of a loaded source grid onto target indices.
// ----------------------------------------------------------------------------
// Usage: drive start with the item fields; an item is taken when start is high
// and busy is low. Mode 0 writes load_value into the source store at
// load_addr (ignored beyond the store); mode 1 queries target point i, j, k.
// Each query yields one result on o_result_value / o_addr_error, marked by a
// one-cycle o_result_valid strobe; loads yield nothing. The receiver cannot
// stall, so results are never held.
// The front end holds busy while it scales an item's indices and while the
// two-deep queue behind it is full; the queue lets it take items while the
// back end works. A load is written as it is popped, leaving the back end
// idle; a query holds it until its result: 8 neighbour addresses issued one
// per cycle into the single-port store pass address registers r_m1, r_m2
// and read register r_rd, then 7 blends, each a multiply then an accumulate
// phase, run on one shared multiplier. A query with a negative coordinate
// reports its error from idle. Configuration uses the APB port; the user must
// write it only while idle; the block does not enforce this. Reset clears control
// state and sets config defaults; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_grid_resampler #(
    parameter int SRC_DEPTH = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [13:0] i_load_addr,
    input  wire logic [31:0] i_load_value,
    input  wire logic [11:0] i_tgt_i,
    input  wire logic [11:0] i_tgt_j,
    input  wire logic [9:0]  i_tgt_k,
    output logic             o_result_valid,
    output logic [31:0]      o_result_value,
    output logic             o_addr_error,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    tgr_pkg::t_cfg  r_cfg;
    tgr_pkg::t_item w_fr_item, w_q_item;
    logic           w_accept, w_push, w_pop, w_full, w_empty, w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_scale    <= 24'd65536;
            r_cfg.x_offset   <= '0;
            r_cfg.y_scale    <= 24'd65536;
            r_cfg.y_offset   <= '0;
            r_cfg.z_scale    <= '0;
            r_cfg.z_offset   <= '0;
            r_cfg.src_ycount <= 13'd1;
            r_cfg.src_zcount <= 11'd1;
        end else if (w_cfg_we) begin
            unique case (paddr[4:2])
                tgr_pkg::REG_X_SCALE:    r_cfg.x_scale    <= pwdata[23:0];
                tgr_pkg::REG_X_OFFSET:   r_cfg.x_offset   <= pwdata;
                tgr_pkg::REG_Y_SCALE:    r_cfg.y_scale    <= pwdata[23:0];
                tgr_pkg::REG_Y_OFFSET:   r_cfg.y_offset   <= pwdata;
                tgr_pkg::REG_Z_SCALE:    r_cfg.z_scale    <= pwdata[23:0];
                tgr_pkg::REG_Z_OFFSET:   r_cfg.z_offset   <= pwdata;
                tgr_pkg::REG_SRC_YCOUNT: r_cfg.src_ycount <= pwdata[12:0];
                default:                 r_cfg.src_zcount <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tgr_pkg::REG_X_SCALE:    prdata = {8'd0, r_cfg.x_scale};
            tgr_pkg::REG_X_OFFSET:   prdata = r_cfg.x_offset;
            tgr_pkg::REG_Y_SCALE:    prdata = {8'd0, r_cfg.y_scale};
            tgr_pkg::REG_Y_OFFSET:   prdata = r_cfg.y_offset;
            tgr_pkg::REG_Z_SCALE:    prdata = {8'd0, r_cfg.z_scale};
            tgr_pkg::REG_Z_OFFSET:   prdata = r_cfg.z_offset;
            tgr_pkg::REG_SRC_YCOUNT: prdata = {19'd0, r_cfg.src_ycount};
            default:                 prdata = {21'd0, r_cfg.src_zcount};
        endcase
    end

    tgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_mode       (i_mode),
        .i_load_addr  (i_load_addr),
        .i_load_value (i_load_value),
        .i_tgt_i      (i_tgt_i),
        .i_tgt_j      (i_tgt_j),
        .i_tgt_k      (i_tgt_k),
        .i_cfg        (r_cfg),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_fr_item),
        .o_busy       (busy)
    );

    tgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fr_item),
        .i_pop   (w_pop),
        .o_data  (w_q_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tgr_back #(
        .SRC_DEPTH (SRC_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_q_item),
        .i_empty (w_empty),
        .i_cfg   (r_cfg),
        .o_pop   (w_pop),
        .o_valid (o_result_valid),
        .o_value (o_result_value),
        .o_error (o_addr_error)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("queue pop while empty");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_addr_error) |-> (o_result_value == 32'd0))
        else $error("error result carries nonzero value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("front end free right after taking an item");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for trilinear_grid_resampler: loads source samples,
// sweeps several register settings (2D, 3D, zero and full counts, extreme
// scales and offsets) and checks every query result against an in-bench
// trilinear predictor kept in step with the source store.
// ----------------------------------------------------------------------------

typedef struct {
    logic [31:0] value;
    logic        err;
} t_expected;

class resample_scoreboard;
    localparam int DEPTH = 16384;

    tgr_pkg::t_cfg cfg;
    logic [31:0] samples [DEPTH];
    bit          loaded  [DEPTH];
    t_expected   pending [$];
    int          failures;

    function new();
        cfg.x_scale    = 24'd65536;
        cfg.x_offset   = '0;
        cfg.y_scale    = 24'd65536;
        cfg.y_offset   = '0;
        cfg.z_scale    = '0;
        cfg.z_offset   = '0;
        cfg.src_ycount = 13'd1;
        cfg.src_zcount = 11'd1;
        failures       = 0;
    endfunction

    static function longint blend(longint a, longint b, longint f);
        longint s;
        s = a * (65536 - f) + b * f + 32768;
        return s >>> 16;
    endfunction

    // Trilinear value at target (i, j, k); reports reads of never-loaded samples.
    function void resample(int ti, int tj, int tk, output t_expected r, output bit unsafe);
        longint      co [3];
        longint      lo [3];
        longint      hi [3];
        longint      fr [3];
        longint      v  [8];
        longint      ym, yp;
        longint unsigned a [8];
        bit          err;
        co[0] = longint'(cfg.x_scale) * ti + longint'(cfg.x_offset);
        co[1] = longint'(cfg.y_scale) * tj + longint'(cfg.y_offset);
        co[2] = longint'(cfg.z_scale) * tk + longint'(cfg.z_offset);
        err = 0;
        unsafe = 0;
        for (int n = 0; n < 3; n++) begin
            if (co[n] < 0) begin
                err = 1;
                lo[n] = 0; hi[n] = 0; fr[n] = 0;
            end else begin
                lo[n] = co[n] >>> 16;
                fr[n] = co[n] & 64'hFFFF;
                hi[n] = lo[n] + ((fr[n] != 0) ? 1 : 0);
            end
        end
        for (int n = 0; n < 8 && !err; n++) begin
            a[n] = (longint'(n[2] ? hi[0] : lo[0]) * longint'(cfg.src_ycount)
                    + (n[1] ? hi[1] : lo[1])) * longint'(cfg.src_zcount)
                   + (n[0] ? hi[2] : lo[2]);
            if (a[n] >= DEPTH) err = 1;
        end
        r.err = err;
        r.value = '0;
        if (err) return;
        for (int n = 0; n < 8; n++) begin
            if (!loaded[a[n]]) unsafe = 1;
            v[n] = longint'($signed(samples[a[n]]));
        end
        for (int n = 0; n < 4; n++) v[n] = blend(v[2*n], v[2*n+1], fr[2]);
        ym = blend(v[0], v[1], fr[1]);
        yp = blend(v[2], v[3], fr[1]);
        r.value = 32'(blend(ym, yp, fr[0]));
    endfunction

    function void note_item(bit mode, logic [13:0] addr, logic [31:0] value,
                            int ti, int tj, int tk);
        t_expected r;
        bit        unsafe;
        if (!mode) begin
            samples[addr] = value;
            loaded[addr]  = 1;
        end else begin
            resample(ti, tj, tk, r, unsafe);
            pending.push_back(r);
        end
    endfunction

    function void check_result(logic [31:0] value, logic err);
        t_expected r;
        if (pending.size() == 0) begin
            $error("unexpected result value=%h addr_error=%b", value, err);
            failures++;
            return;
        end
        r = pending.pop_front();
        if (value !== r.value) begin
            $error("result_value expected %h actual %h", r.value, value);
            failures++;
        end
        if (err !== r.err) begin
            $error("addr_error expected %b actual %b", r.err, err);
            failures++;
        end
    endfunction
endclass

module tb_top;
    logic        i_clk, i_rst_n;
    logic        start, busy;
    logic        i_mode;
    logic [13:0] i_load_addr;
    logic [31:0] i_load_value;
    logic [11:0] i_tgt_i, i_tgt_j;
    logic [9:0]  i_tgt_k;
    logic        o_result_valid, o_addr_error;
    logic [31:0] o_result_value;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    resample_scoreboard sb;
    bit steady;

    trilinear_grid_resampler DUT (
        .i_clk, .i_rst_n, .start, .busy,
        .i_mode, .i_load_addr, .i_load_value, .i_tgt_i, .i_tgt_j, .i_tgt_k,
        .o_result_valid, .o_result_value, .o_addr_error,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("trilinear_grid_resampler regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result_value, o_addr_error);
    end

    task automatic send_item(bit mode, logic [13:0] addr, logic [31:0] value,
                             int ti, int tj, int tk);
        start        <= 1'b1;
        i_mode       <= mode;
        i_load_addr  <= addr;
        i_load_value <= value;
        i_tgt_i      <= 12'(ti);
        i_tgt_j      <= 12'(tj);
        i_tgt_k      <= 10'(tk);
        do @(posedge i_clk); while (busy);
        sb.note_item(mode, addr, value, ti, tj, tk);
        if (!steady && $urandom_range(0, 99) < 33) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] sample_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Send a query only if it reads no never-loaded sample.
    task automatic try_query(bit wide);
        t_expected r;
        bit        unsafe;
        int        ti, tj, tk;
        for (int n = 0; n < 20; n++) begin
            ti = wide ? $urandom_range(0, 4095) : $urandom_range(0, 7);
            tj = wide ? $urandom_range(0, 4095) : $urandom_range(0, 7);
            tk = wide ? $urandom_range(0, 1023) : $urandom_range(0, 5);
            sb.resample(ti, tj, tk, r, unsafe);
            if (!unsafe) begin
                send_item(1'b1, '0, '0, ti, tj, tk);
                return;
            end
        end
    endtask

    // Wait for every result, then let the back end drain.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(tgr_pkg::t_cfg c);
        reg_write(tgr_pkg::REG_X_SCALE,    32'(c.x_scale));
        reg_write(tgr_pkg::REG_X_OFFSET,   c.x_offset);
        reg_write(tgr_pkg::REG_Y_SCALE,    32'(c.y_scale));
        reg_write(tgr_pkg::REG_Y_OFFSET,   c.y_offset);
        reg_write(tgr_pkg::REG_Z_SCALE,    32'(c.z_scale));
        reg_write(tgr_pkg::REG_Z_OFFSET,   c.z_offset);
        reg_write(tgr_pkg::REG_SRC_YCOUNT, 32'(c.src_ycount));
        reg_write(tgr_pkg::REG_SRC_ZCOUNT, 32'(c.src_zcount));
        @(posedge i_clk);
        sb.cfg = c;
    endtask

    function automatic tgr_pkg::t_cfg pick_config(int phase);
        tgr_pkg::t_cfg c;
        bit   flat;
        flat = (phase % 3 == 1);
        c.x_scale    = 24'($urandom_range(0, 32'h30000));
        c.y_scale    = 24'($urandom_range(0, 32'h30000));
        c.x_offset   = 32'($urandom_range(0, 32'h48000)) - 32'h8000;
        c.y_offset   = 32'($urandom_range(0, 32'h48000)) - 32'h8000;
        c.z_scale    = flat ? '0 : 24'($urandom_range(0, 32'h20000));
        c.z_offset   = flat ? '0 : 32'($urandom_range(0, 32'h38000)) - 32'h4000;
        c.src_ycount = 13'($urandom_range(1, 8));
        c.src_zcount = flat ? 11'd1 : 11'($urandom_range(2, 6));
        case (phase)
            1: begin
                c.x_scale = 24'hFF_FFFF; c.y_scale = 24'hFF_FFFF; c.z_scale = 24'hFF_FFFF;
                c.x_offset = 32'h7FFF_FFFF; c.y_offset = 32'h7FFF_FFFF;
                c.z_offset = 32'h7FFF_FFFF;
            end
            2: begin
                c.x_offset = 32'h8000_0000; c.y_offset = 32'h8000_0000;
                c.z_offset = 32'h8000_0000;
            end
            3: begin
                c.src_ycount = '0; c.src_zcount = '0;
            end
            4: begin
                c.src_ycount = 13'h1FFF; c.src_zcount = 11'h7FF;
                c.x_scale = '0; c.x_offset = '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        sb = new();
        i_rst_n = 0; start = 0; i_mode = 0; i_load_addr = '0; i_load_value = '0;
        i_tgt_i = '0; i_tgt_j = '0; i_tgt_k = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        steady = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme samples at both ends of the store, then simple queries
        send_item(1'b0, 14'd0, 32'h7FFF_FFFF, 0, 0, 0);
        send_item(1'b0, 14'd1, 32'h8000_0000, 0, 0, 0);
        send_item(1'b0, 14'd2, 32'h0000_0000, 0, 0, 0);
        send_item(1'b0, 14'd3, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(1'b0, 14'd4095, 32'h1234_5678, 0, 0, 0);
        send_item(1'b0, 14'h3FFF, 32'h5555_AAAA, 0, 0, 0);
        send_item(1'b1, '0, '0, 0, 0, 0);
        send_item(1'b1, '0, '0, 1, 0, 0);
        send_item(1'b1, '0, '0, 0, 1, 1023);
        send_item(1'b1, '0, '0, 1, 1, 0);
        send_item(1'b1, '0, '0, 4095, 0, 0);

        // fill the low store so queries have neighbors to read
        for (int a = 0; a < 512; a++) send_item(1'b0, 14'(a), sample_value(), 0, 0, 0);

        for (int phase = 0; phase < 12; phase++) begin
            drain();
            if (phase > 0) apply_config(pick_config(phase));
            for (int n = 0; n < 110; n++) begin
                steady = (phase == 5);
                if (phase == 7 && n == 55) drain();
                if ($urandom_range(0, 99) < 12)
                    send_item(1'b0, 14'($urandom()), sample_value(), 0, 0, 0);
                else
                    try_query($urandom_range(0, 9) == 0);
            end
        end
        steady = 0;

        start <= 1'b0;
        fork
            begin
                while (sb.pending.size() != 0) @(posedge i_clk);
                repeat (60) @(posedge i_clk);
            end
            begin
                repeat (20000) @(posedge i_clk);
                sb.failures++;
            end
        join_any
        disable fork;
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("trilinear_grid_resampler regression: pass");
        else
            $display("trilinear_grid_resampler regression: fail");
        $finish;
    end
endmodule
